### hdl/assert_macros.svh
// Assertion helpers for the checker file (gdt_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is off while reset is held.
`define GDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/gdt_pkg.sv
package gdt_pkg;

  localparam int unsigned TW         = 31;
  localparam logic [TW-1:0] T_SAT    = 31'h7FFF_FFFF;
  localparam int unsigned DIVIDEND_W = 48;
  localparam int unsigned DIVISOR_W  = 32;
  localparam int unsigned CW         = 4;
  localparam int unsigned IDX_W      = 12;

  localparam logic [2:0] CFG_GMIN_X = 3'd0;
  localparam logic [2:0] CFG_GMIN_Y = 3'd1;
  localparam logic [2:0] CFG_GMIN_Z = 3'd2;
  localparam logic [2:0] CFG_CS_X   = 3'd3;
  localparam logic [2:0] CFG_CS_Y   = 3'd4;
  localparam logic [2:0] CFG_CS_Z   = 3'd5;

  // One set-up ray handed from the front end to the walker.
  typedef struct packed {
    logic                   outside;
    logic [2:0]             step_pos;
    logic [2:0][CW-1:0]     pos;
    logic [2:0][TW-1:0]     tmax;
    logic [2:0][TW-1:0]     tdelta;
  } gdt_ray_t;

  typedef struct packed {
    logic                   start;
    logic [DIVIDEND_W-1:0]  dividend;
    logic [DIVISOR_W-1:0]   divisor;
  } gdt_div_req_t;

  typedef struct packed {
    logic                   done;
    logic [DIVIDEND_W-1:0]  quot;
    logic [DIVISOR_W-1:0]   rem;
  } gdt_div_rsp_t;

endpackage

### hdl/gdt_if.sv
interface gdt_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface gdt_cell_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cell_x;
  logic [3:0]  cell_y;
  logic [3:0]  cell_z;
  logic [11:0] cell_index;
  logic [30:0] t_exit;
  logic        outside;
  logic        last;
  modport source (output valid, cell_x, cell_y, cell_z, cell_index, t_exit, outside, last,
                  input ready);
  modport sink (input valid, cell_x, cell_y, cell_z, cell_index, t_exit, outside, last,
                output ready);
endinterface

interface gdt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/grid_ray_cell_traversal.sv
// Ray walker through a cubic grid of GRID_SIZE cells per side.
// ray_i takes one ray (origin and direction, signed Q16.16) per handshake.
// cell_o gives one word per visited cell, in walk order, with the cell
// coordinates, linear index and exit distance; the final word of a ray has
// last set. A ray that starts outside the grid gives a single word with
// outside and last set. cfg_i writes the grid corner and cell sizes; it is
// always ready. It is to be written only while the block is idle; the block
// itself does not enforce this. Set-up runs on one shared divider that yields
// one quotient bit per cycle; each division holds the front until it is done,
// and a zero direction component skips both of its divisions. ray_i is ready
// again the cycle after the hand-off of a ray into the queue. The walker then
// gives one cell per cycle while cell_o does not stall, up to 3*GRID_SIZE-2
// cells, and overlaps with the set-up of the next ray through a two-entry
// queue. The first word of a ray passes through the queue, the walker's ray
// register and the output register; an outside word goes from the queue
// straight to the output register.
// When cell_o stalls, the output word holds and the walker waits; once the
// queue is full the front holds its finished ray and ray_i stays not ready.
// Reset empties the queue, aborts any walk and sets corner 0 and cell size 1.0.
module grid_ray_cell_traversal #(
  parameter int unsigned GRID_SIZE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gdt_ray_if.sink     ray_i,
  gdt_cell_if.source  cell_o,
  gdt_cfg_if.sink     cfg_i
);
  import gdt_pkg::*;

  logic signed [2:0][31:0] gmin_q;
  logic        [2:0][30:0] cs_q;
  gdt_div_req_t            div_req;
  gdt_div_rsp_t            div_rsp;
  logic                    push, full, pop, empty;
  gdt_ray_t                push_data, pop_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gmin_q <= '0;
      cs_q   <= {3{31'd65536}};
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_GMIN_X: gmin_q[0] <= cfg_i.data;
        CFG_GMIN_Y: gmin_q[1] <= cfg_i.data;
        CFG_GMIN_Z: gmin_q[2] <= cfg_i.data;
        CFG_CS_X:   cs_q[0]   <= cfg_i.data[30:0];
        CFG_CS_Y:   cs_q[1]   <= cfg_i.data[30:0];
        CFG_CS_Z:   cs_q[2]   <= cfg_i.data[30:0];
        default: ;
      endcase
    end
  end

  gdt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  gdt_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ray_i       (ray_i),
    .gmin_i      (gmin_q),
    .cs_i        (cs_q),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  gdt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  gdt_back #(.GRID_SIZE(GRID_SIZE)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_data_i (pop_data),
    .empty_i    (empty),
    .pop_o      (pop),
    .cell_o     (cell_o)
  );

endmodule

### hdl/gdt_div.sv
module gdt_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gdt_pkg::gdt_div_req_t req_i,
  output gdt_pkg::gdt_div_rsp_t rsp_o
);
  import gdt_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] num_q;
  logic [DIVISOR_W-1:0]  rem_q, den_q;
  logic [DIVISOR_W:0]    rem_sh, rem_sub;
  logic                  ge;

  // Restoring division, one quotient bit per cycle; the dividend shifts out
  // at the top while quotient bits shift in at the bottom.
  always_comb begin
    rem_sh  = {rem_q, num_q[DIVIDEND_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIVIDEND_W-2:0], ge};
      rem_q <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q;

endmodule

### hdl/gdt_fifo.sv
module gdt_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gdt_pkg::gdt_ray_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output gdt_pkg::gdt_ray_t pop_data_o,
  output logic              empty_o
);
  import gdt_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);

  gdt_ray_t         mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;

  assign full_o     = cnt_q == (PW+1)'(DEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

### hdl/gdt_front.sv
module gdt_front #(
  parameter int unsigned GRID_SIZE = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gdt_ray_if.sink                     ray_i,
  input  logic signed [2:0][31:0]     gmin_i,
  input  logic        [2:0][30:0]     cs_i,
  output gdt_pkg::gdt_div_req_t       div_req_o,
  input  gdt_pkg::gdt_div_rsp_t       div_rsp_i,
  output logic                        push_o,
  output gdt_pkg::gdt_ray_t           push_data_o,
  input  logic                        full_i
);
  import gdt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_PUSH  = 2'd3;
  localparam logic [3:0] OP_LAST = 4'd8;

  logic [1:0]              state_q;
  logic [3:0]              op_q;
  logic signed [2:0][32:0] off_q;
  logic signed [2:0][31:0] dir_q;
  logic [2:0][30:0]        cs_q;
  logic [2:0][30:0]        rem_q;
  gdt_ray_t                ray_q;

  logic [1:0]  ax;
  logic        is_cell, is_tmax, dir_zero, step_pos;
  logic [31:0] dmag;
  logic [30:0] mag;
  logic        sat;

  // Operations 0-2 find the start cell, 3-5 tmax and 6-8 tdelta per axis.
  always_comb begin
    if (op_q < 4'd3) ax = op_q[1:0];
    else if (op_q < 4'd6) ax = 2'(op_q - 4'd3);
    else ax = 2'(op_q - 4'd6);
    is_cell  = op_q < 4'd3;
    is_tmax  = !is_cell && op_q < 4'd6;
    dir_zero = dir_q[ax] == '0;
    step_pos = !dir_zero && !dir_q[ax][31];
    dmag     = dir_q[ax][31] ? 32'(-dir_q[ax]) : 32'(dir_q[ax]);
    mag      = step_pos ? cs_q[ax] - rem_q[ax] : rem_q[ax];
    sat      = div_rsp_i.quot[DIVIDEND_W-1:TW] != '0;

    div_req_o.start    = 1'b0;
    div_req_o.dividend = '0;
    div_req_o.divisor  = '0;
    if (state_q == S_ISSUE) begin
      if (is_cell) begin
        div_req_o.start    = !off_q[ax][32];
        div_req_o.dividend = DIVIDEND_W'(off_q[ax][31:0]);
        div_req_o.divisor  = DIVISOR_W'(cs_q[ax]);
      end else begin
        div_req_o.start    = !dir_zero;
        div_req_o.dividend = is_tmax ? DIVIDEND_W'({mag, 16'h0})
                                     : DIVIDEND_W'({cs_q[ax], 16'h0});
        div_req_o.divisor  = dmag;
      end
    end
  end

  assign ray_i.ready = state_q == S_IDLE;
  assign push_o      = state_q == S_PUSH && !full_i;
  assign push_data_o = ray_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (ray_i.valid) begin
            state_q <= S_ISSUE;
            op_q    <= '0;
          end
        end
        S_ISSUE: begin
          if (is_cell && off_q[ax][32]) begin
            state_q <= S_PUSH;
          end else if (!is_cell && dir_zero) begin
            if (op_q == OP_LAST) state_q <= S_PUSH;
            else op_q <= op_q + 1'b1;
          end else begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_rsp_i.done) begin
            if (is_cell && div_rsp_i.quot >= DIVIDEND_W'(GRID_SIZE)) begin
              state_q <= S_PUSH;
            end else if (op_q == OP_LAST) begin
              state_q <= S_PUSH;
            end else begin
              state_q <= S_ISSUE;
              op_q    <= op_q + 1'b1;
            end
          end
        end
        S_PUSH: begin
          if (!full_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The walker ignores every other field of an outside word.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && ray_i.valid) begin
      off_q[0] <= 33'(ray_i.origin_x) - 33'($signed(gmin_i[0]));
      off_q[1] <= 33'(ray_i.origin_y) - 33'($signed(gmin_i[1]));
      off_q[2] <= 33'(ray_i.origin_z) - 33'($signed(gmin_i[2]));
      dir_q[0] <= ray_i.dir_x;
      dir_q[1] <= ray_i.dir_y;
      dir_q[2] <= ray_i.dir_z;
      for (int a = 0; a < 3; a++) begin
        cs_q[a] <= (cs_i[a] == '0) ? 31'd1 : cs_i[a];
      end
      ray_q <= '0;
    end else if (state_q == S_ISSUE) begin
      if (is_cell && off_q[ax][32]) begin
        ray_q.outside <= 1'b1;
      end else if (!is_cell && dir_zero) begin
        ray_q.step_pos[ax] <= 1'b0;
        if (is_tmax) ray_q.tmax[ax] <= T_SAT;
        else ray_q.tdelta[ax] <= '0;
      end
    end else if (state_q == S_WAIT && div_rsp_i.done) begin
      if (is_cell) begin
        if (div_rsp_i.quot >= DIVIDEND_W'(GRID_SIZE)) begin
          ray_q.outside <= 1'b1;
        end else begin
          ray_q.pos[ax] <= div_rsp_i.quot[CW-1:0];
          rem_q[ax]     <= div_rsp_i.rem[TW-1:0];
        end
      end else begin
        ray_q.step_pos[ax] <= step_pos;
        if (is_tmax) ray_q.tmax[ax] <= sat ? T_SAT : div_rsp_i.quot[TW-1:0];
        else ray_q.tdelta[ax] <= sat ? T_SAT : div_rsp_i.quot[TW-1:0];
      end
    end
  end

endmodule

### hdl/gdt_back.sv
module gdt_back #(
  parameter int unsigned GRID_SIZE = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gdt_pkg::gdt_ray_t pop_data_i,
  input  logic              empty_i,
  output logic              pop_o,
  gdt_cell_if.source        cell_o
);
  import gdt_pkg::*;

  localparam int unsigned MAX_CELLS = 3 * GRID_SIZE - 2;
  localparam int unsigned KW        = $clog2(MAX_CELLS);

  logic                active_q;
  logic [KW-1:0]       k_q;
  gdt_ray_t            ray_q;

  logic                out_valid_q;
  logic [2:0][CW-1:0]  out_cell_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic [TW-1:0]       out_t_q;
  logic                out_outside_q, out_last_q;

  logic                slot_free, emit;
  logic [1:0]          ax;
  logic [TW-1:0]       t_sel, td_sel;
  logic [TW:0]         t_sum;
  logic                done;
  logic [IDX_W-1:0]    idx;

  assign slot_free = !out_valid_q || cell_o.ready;
  assign pop_o     = !active_q && !empty_i && slot_free;
  assign emit      = active_q && slot_free;

  // Smallest tmax wins; on equal values the later axis wins (z before y before x).
  always_comb begin
    if (ray_q.tmax[0] < ray_q.tmax[1]) ax = (ray_q.tmax[0] < ray_q.tmax[2]) ? 2'd0 : 2'd2;
    else ax = (ray_q.tmax[1] < ray_q.tmax[2]) ? 2'd1 : 2'd2;
    t_sel  = ray_q.tmax[ax];
    td_sel = ray_q.tdelta[ax];
    t_sum  = {1'b0, t_sel} + {1'b0, td_sel};
    done   = (ray_q.step_pos[ax] ? ray_q.pos[ax] == CW'(GRID_SIZE - 1)
                                 : ray_q.pos[ax] == '0)
             || k_q == KW'(MAX_CELLS - 1);
    idx    = IDX_W'(ray_q.pos[0]) + IDX_W'(ray_q.pos[1]) * IDX_W'(GRID_SIZE)
             + IDX_W'(ray_q.pos[2]) * IDX_W'(GRID_SIZE * GRID_SIZE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      out_valid_q <= (pop_o && pop_data_i.outside) || emit
                     || (out_valid_q && !cell_o.ready);
      if (pop_o) begin
        k_q <= '0;
        if (!pop_data_i.outside) active_q <= 1'b1;
      end else if (emit) begin
        k_q <= k_q + 1'b1;
        if (done) active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ray_q <= pop_data_i;
      if (pop_data_i.outside) begin
        out_cell_q    <= '0;
        out_idx_q     <= '0;
        out_t_q       <= '0;
        out_outside_q <= 1'b1;
        out_last_q    <= 1'b1;
      end
    end else if (emit) begin
      out_cell_q    <= ray_q.pos;
      out_idx_q     <= idx;
      out_t_q       <= t_sel;
      out_outside_q <= 1'b0;
      out_last_q    <= done;
      ray_q.tmax[ax] <= t_sum[TW] ? T_SAT : t_sum[TW-1:0];
      ray_q.pos[ax]  <= ray_q.step_pos[ax] ? ray_q.pos[ax] + 1'b1 : ray_q.pos[ax] - 1'b1;
    end
  end

  assign cell_o.valid      = out_valid_q;
  assign cell_o.cell_x     = out_cell_q[0];
  assign cell_o.cell_y     = out_cell_q[1];
  assign cell_o.cell_z     = out_cell_q[2];
  assign cell_o.cell_index = out_idx_q;
  assign cell_o.t_exit     = out_t_q;
  assign cell_o.outside    = out_outside_q;
  assign cell_o.last       = out_last_q;

endmodule

### hdl/gdt_checker.sv
`include "assert_macros.svh"

module gdt_checker #(
  parameter int unsigned GRID_SIZE = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  cell_x,
  input logic [3:0]  cell_y,
  input logic [3:0]  cell_z,
  input logic [11:0] cell_index,
  input logic [30:0] t_exit,
  input logic        outside,
  input logic        last,
  input logic        cfg_ready
);

  `GDT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(cell_index) && $stable(t_exit) && $stable(last), "output word changed while stalled")
  `GDT_ASSERT(a_outside_word, out_valid && outside |-> last && cell_index == 12'd0 && t_exit == 31'd0, "outside word is not a lone zero word")
  `GDT_ASSERT(a_index, out_valid && !outside |-> cell_index == 12'(12'(cell_x) + 12'(cell_y) * 12'(GRID_SIZE) + 12'(cell_z) * 12'(GRID_SIZE * GRID_SIZE)), "linear index does not match coordinates")
  `GDT_ASSERT_ALWAYS(a_cfg_ready, !rst_ni || cfg_ready, "configuration port not ready")

endmodule

bind grid_ray_cell_traversal gdt_checker #(.GRID_SIZE(GRID_SIZE)) u_gdt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (cell_o.valid),
  .out_ready  (cell_o.ready),
  .cell_x     (cell_o.cell_x),
  .cell_y     (cell_o.cell_y),
  .cell_z     (cell_o.cell_z),
  .cell_index (cell_o.cell_index),
  .t_exit     (cell_o.t_exit),
  .outside    (cell_o.outside),
  .last       (cell_o.last),
  .cfg_ready  (cfg_i.ready)
);

### tb/tb_if.sv
`timescale 1ns / 1ps

// The channel interfaces come with the RTL (gdt_ray_if, gdt_cell_if, gdt_cfg_if).
// This file holds the testbench's own word types, which tb.sv uses.
package tb_word_pkg;

  typedef struct packed {
    logic [3:0]  cx;
    logic [3:0]  cy;
    logic [3:0]  cz;
    logic [11:0] idx;
    logic [30:0] t;
    logic        outside;
    logic        last;
  } cell_word_t;

  typedef struct {
    logic signed [31:0] org[3];
    logic signed [31:0] dir[3];
  } ray_word_t;

endpackage

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import gdt_pkg::*;
  import tb_word_pkg::*;

  localparam int GS = 16;
  localparam int MAX_CELLS = 3 * GS - 2;
  localparam longint CYCLE_LIMIT = 2_000_000;

  class cell_walk_board;
    logic signed [31:0] gmin[3];
    logic [30:0]        csize[3];
    cell_word_t         pending[$];
    int                 errors;

    function void reset_regs();
      for (int a = 0; a < 3; a++) begin
        gmin[a] = 0;
        csize[a] = 31'd65536;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] ix, logic [31:0] d);
      case (ix)
        CFG_GMIN_X: gmin[0] = d;
        CFG_GMIN_Y: gmin[1] = d;
        CFG_GMIN_Z: gmin[2] = d;
        CFG_CS_X:   csize[0] = d[30:0];
        CFG_CS_Y:   csize[1] = d[30:0];
        CFG_CS_Z:   csize[2] = d[30:0];
        default: ;
      endcase
    endfunction

    static function longint unsigned sat(longint unsigned v);
      return (v > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : v;
    endfunction

    function void push_cell(int c[3], longint unsigned t, bit outside, bit last);
      cell_word_t w;
      w.cx = 4'(c[0]);
      w.cy = 4'(c[1]);
      w.cz = 4'(c[2]);
      w.idx = 12'(c[0] + c[1] * GS + c[2] * GS * GS);
      w.t = t[30:0];
      w.outside = outside;
      w.last = last;
      pending.push_back(w);
    endfunction

    // Expected walk for one accepted ray.
    function void note_ray(ray_word_t r);
      longint cs[3], off, bound, diff;
      longint unsigned q, mag, dmag, tmax[3], tdel[3];
      int cur[3], stp[3], exitc[3], zero[3], ax;
      bit done;
      zero = '{0, 0, 0};
      for (int a = 0; a < 3; a++) begin
        cs[a] = (csize[a] == 0) ? 1 : longint'(csize[a]);
        off = longint'(r.org[a]) - longint'(gmin[a]);
        q = (off < 0) ? 0 : longint'(off) / cs[a];
        if (off < 0 || q >= GS) begin
          push_cell(zero, 0, 1'b1, 1'b1);
          return;
        end
        cur[a] = int'(q);
      end
      for (int a = 0; a < 3; a++) begin
        if (r.dir[a] > 0) begin
          stp[a] = 1;
          exitc[a] = GS;
          bound = longint'(gmin[a]) + longint'(cur[a] + 1) * cs[a];
        end else begin
          stp[a] = -1;
          exitc[a] = -1;
          bound = longint'(gmin[a]) + longint'(cur[a]) * cs[a];
        end
        if (r.dir[a] == 0) begin
          tmax[a] = 64'h7FFF_FFFF;
          tdel[a] = 0;
        end else begin
          diff = bound - longint'(r.org[a]);
          mag = (diff < 0) ? -diff : diff;
          dmag = (r.dir[a] < 0) ? -longint'(r.dir[a]) : longint'(r.dir[a]);
          tmax[a] = sat((mag << 16) / dmag);
          tdel[a] = sat((longint'(cs[a]) << 16) / dmag);
        end
      end
      for (int k = 0; k < MAX_CELLS; k++) begin
        if (tmax[0] < tmax[1]) ax = (tmax[0] < tmax[2]) ? 0 : 2;
        else ax = (tmax[1] < tmax[2]) ? 1 : 2;
        done = (cur[ax] + stp[ax] == exitc[ax]) || (k == MAX_CELLS - 1);
        push_cell(cur, tmax[ax], 1'b0, done);
        if (done) return;
        cur[ax] += stp[ax];
        tmax[ax] = sat(tmax[ax] + tdel[ax]);
      end
    endfunction

    function void check_cell(cell_word_t got);
      cell_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected cell word %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.cx !== e.cx) begin $error("cell_x exp %0d got %0d", e.cx, got.cx); errors++; end
      if (got.cy !== e.cy) begin $error("cell_y exp %0d got %0d", e.cy, got.cy); errors++; end
      if (got.cz !== e.cz) begin $error("cell_z exp %0d got %0d", e.cz, got.cz); errors++; end
      if (got.idx !== e.idx) begin
        $error("cell_index exp %0d got %0d", e.idx, got.idx); errors++;
      end
      if (got.t !== e.t) begin $error("t_exit exp %0h got %0h", e.t, got.t); errors++; end
      if (got.outside !== e.outside) begin
        $error("outside exp %0b got %0b", e.outside, got.outside); errors++;
      end
      if (got.last !== e.last) begin
        $error("last exp %0b got %0b", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  longint cycles = 0;
  bit calm = 1'b0;  // no idling on either side while set
  cell_walk_board board = new();

  gdt_ray_if  ray_ch();
  gdt_cell_if cell_ch();
  gdt_cfg_if  cfg_ch();

  grid_ray_cell_traversal #(.GRID_SIZE(GS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .ray_i(ray_ch.sink), .cell_o(cell_ch.source), .cfg_i(cfg_ch.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    ray_ch.valid = 1'b0;
    ray_ch.origin_x = 0; ray_ch.origin_y = 0; ray_ch.origin_z = 0;
    ray_ch.dir_x = 0; ray_ch.dir_y = 0; ray_ch.dir_z = 0;
    cell_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_GMIN_X;
    cfg_ch.data = 0;
    board.reset_regs();
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: check each accepted word, then stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cell_ch.valid && cell_ch.ready)
        board.check_cell({cell_ch.cell_x, cell_ch.cell_y, cell_ch.cell_z,
                          cell_ch.cell_index, cell_ch.t_exit, cell_ch.outside,
                          cell_ch.last});
      cell_ch.ready <= calm || ($urandom_range(99) >= 35);
    end
  end

  task automatic write_cfg(logic [2:0] ix, logic [31:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= ix;
    cfg_ch.data <= d;
    do @(posedge clk_i); while (!cfg_ch.ready);
    board.write_reg(ix, d);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_ray(ray_word_t r);
    while (!calm && $urandom_range(99) < 35) @(posedge clk_i);
    ray_ch.valid <= 1'b1;
    ray_ch.origin_x <= r.org[0]; ray_ch.origin_y <= r.org[1]; ray_ch.origin_z <= r.org[2];
    ray_ch.dir_x <= r.dir[0]; ray_ch.dir_y <= r.dir[1]; ray_ch.dir_z <= r.dir[2];
    do @(posedge clk_i); while (!ray_ch.ready);
    board.note_ray(r);
    ray_ch.valid <= 1'b0;
    // The block is busy with set-up for this cycle anyway.
    @(posedge clk_i);
  endtask

  // Waits for all expected words, then covers the set-up of a ray still in flight.
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  function automatic ray_word_t make_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz);
    ray_word_t r;
    r.org = '{ox, oy, oz};
    r.dir = '{dx, dy, dz};
    return r;
  endfunction

  // Origin mostly inside the current grid; direction random with small and zero parts.
  function automatic ray_word_t rand_ray();
    ray_word_t r;
    longint v;
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(9))
        0: r.org[a] = $urandom;
        1: r.org[a] = board.gmin[a] - $urandom_range(3);
        default: begin
          v = longint'(board.gmin[a]) +
              (longint'($urandom) * board.csize[a] * GS) / 64'h1_0000_0000;
          r.org[a] = v;
        end
      endcase
      case ($urandom_range(7))
        0: r.dir[a] = 0;
        1: r.dir[a] = $urandom;
        2: r.dir[a] = $signed($urandom_range(255)) - 128;
        default: r.dir[a] = $signed($urandom_range(32'h3_0000)) - 32'sh1_8000;
      endcase
    end
    return r;
  endfunction

  task automatic random_rays(int n);
    for (int i = 0; i < n; i++) send_ray(rand_ray());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rays at reset settings: unit cells from the origin.
    send_ray(make_ray(32'sh8_8000, 32'sh8_8000, 32'sh8_8000, 32'sh1_0000, 0, 0));
    send_ray(make_ray(32'sh8_8000, 32'sh8_8000, 32'sh8_8000, 0, 0, 0));
    send_ray(make_ray(32'sh8_0000, 32'sh8_0000, 32'sh8_0000, 32'sh1_0000, 32'sh1_0000,
                      32'sh1_0000));
    send_ray(make_ray(0, 0, 0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
    send_ray(make_ray(32'sh10_0000, 0, 0, 1, 1, 1));
    send_ray(make_ray(-1, 0, 0, 1, 1, 1));
    send_ray(make_ray(32'shF_FFFF, 32'shF_FFFF, 32'shF_FFFF, -1, -1, -1));
    send_ray(make_ray(32'sh7FFF_FFFF, 0, 0, 1, 1, 1));
    send_ray(make_ray(32'sh8000_0000, 0, 0, 1, 1, 1));
    send_ray(make_ray(32'sh1_8000, 32'sh1_8000, 32'sh1_8000, 32'sh7FFF_FFFF,
                      32'sh8000_0000, 1));
    send_ray(make_ray(32'sh4_0000, 32'sh4_0000, 32'sh4_0000, -32'sh1_0000, 0, 32'sh1_0000));
    send_ray(make_ray(32'sh2_0000, 32'sh3_0000, 32'sh4_0000, 0, 32'sh1_0000, 0));
    drain();

    // Extreme sizes and corners, including zero cell size.
    write_cfg(CFG_GMIN_X, 32'h8000_0000);
    write_cfg(CFG_GMIN_Y, 32'h7FFF_0000);
    write_cfg(CFG_GMIN_Z, 32'hFFFF_0000);
    write_cfg(CFG_CS_X, 32'h7FFF_FFFF);
    write_cfg(CFG_CS_Y, 32'h0000_0000);
    write_cfg(CFG_CS_Z, 32'h0000_0001);
    send_ray(make_ray(32'sh8000_0000, 32'sh7FFF_0005, 32'shFFFF_0003, 1, -1, 1));
    send_ray(make_ray(32'sh0, 32'sh7FFF_0000, 32'shFFFF_0000, 32'sh7FFF_FFFF, 0,
                      32'sh8000_0000));
    random_rays(40);
    drain();

    // Typical settings; a long calm stretch, then a drain and a stretch with random stalls.
    write_cfg(CFG_GMIN_X, 32'hFFF8_0000);
    write_cfg(CFG_GMIN_Y, 32'h0001_0000);
    write_cfg(CFG_GMIN_Z, 32'hFFFF_8000);
    write_cfg(CFG_CS_X, 32'h0000_8000);
    write_cfg(CFG_CS_Y, 32'h0002_0000);
    write_cfg(CFG_CS_Z, 32'h0001_0000);
    calm = 1'b1;
    random_rays(60);
    calm = 1'b0;
    drain();
    random_rays(150);
    drain();

    write_cfg(CFG_GMIN_X, 0);
    write_cfg(CFG_GMIN_Y, 0);
    write_cfg(CFG_GMIN_Z, 0);
    write_cfg(CFG_CS_X, 32'h0000_0100);
    write_cfg(CFG_CS_Y, 32'h0000_0100);
    write_cfg(CFG_CS_Z, 32'h0000_0100);
    random_rays(200);
    drain();

    if (board.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### grid_ray_cell_traversal.f
+incdir+hdl
hdl/gdt_pkg.sv
hdl/gdt_if.sv
hdl/gdt_div.sv
hdl/gdt_fifo.sv
hdl/gdt_front.sv
hdl/gdt_back.sv
hdl/grid_ray_cell_traversal.sv
hdl/gdt_checker.sv
tb/tb_if.sv
tb/tb.sv
